>>> src/bsr_pkg.sv
// Package for the bisection root search block: codes, register map and
// configuration types. Used by every module in src.
package bsr_pkg;

	localparam int TOL_WIDTH      = 31;
	localparam int LIM_WIDTH      = 7;
	localparam int APB_DATA_WIDTH = 32;
	localparam int APB_ADDR_WIDTH = 3;
	localparam int STATUS_WIDTH   = 2;

	localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);
	localparam logic [LIM_WIDTH-1:0] LIM_RESET = LIM_WIDTH'(100);

	// Register index taken from paddr[2]
	typedef enum logic [0:0] {
		CFG_TOLERANCE  = 1'b0,
		CFG_ITER_LIMIT = 1'b1
	} cfg_sel_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LOW  = 2'd1,
		PH_HIGH = 2'd2,
		PH_MID  = 2'd3
	} phase_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_SUCCESS = 2'd0,
		ST_LIMIT   = 2'd1,
		ST_NO_SIGN = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic {
		KIND_REQUEST = 1'b0,
		KIND_DONE    = 1'b1
	} kind_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_VALUE = 1'b1
	} op_t;

	typedef struct packed {
		logic [TOL_WIDTH-1:0] tolerance;
		logic [LIM_WIDTH-1:0] iteration_limit;
	} cfg_t;

endpackage

>>> src/bsr_if.sv
// Stream interfaces of the bisection root search: input items and results.
// Valid/ready handshake; depends on nothing but the parameters given.
interface bsr_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [VALUE_WIDTH-1:0] bracket_low;
	logic [VALUE_WIDTH-1:0] bracket_high;
	logic [VALUE_WIDTH-1:0] func_value;
	logic                   value_invalid;

	modport source (
		output valid, op, bracket_low, bracket_high, func_value, value_invalid,
		input  ready
	);
	modport sink (
		input  valid, op, bracket_low, bracket_high, func_value, value_invalid,
		output ready
	);
endinterface

interface bsr_out_if #(
	parameter int VALUE_WIDTH = 32,
	parameter int ITER_WIDTH  = 7
);
	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [VALUE_WIDTH-1:0] query_point;
	logic [1:0]             status;
	logic [VALUE_WIDTH-1:0] root;
	logic [ITER_WIDTH-1:0]  iterations_used;

	modport source (
		output valid, kind, query_point, status, root, iterations_used,
		input  ready
	);
	modport sink (
		input  valid, kind, query_point, status, root, iterations_used,
		output ready
	);
endinterface

>>> src/bisection_root_search.sv
// Bisection root search that drives an external function evaluator. A start
// beat (op 0) carries the bracket; the block answers with a request to evaluate
// f at the low end, then the high end, then successive midpoints, each value
// beat (op 1) returning f at the point last requested or flagging it invalid.
// The search ends with one done beat holding status, root and the number of
// midpoint evaluations. A value beat while no search runs is dropped silently,
// and a start beat always aborts any running search. Each beat is captured in
// an input register, decided in one pass of halving, sign and magnitude logic
// against the search state, and its result is loaded into an output register
// once that register is free or being drained: the block takes one beat per
// cycle while the output side does not stall. While a result waits on the
// output side the input register still takes one beat; a value beat that makes
// no result drops through, but one that makes a result holds the input until
// the sink drains the output. The external evaluator sets the true pace.
// Configure tolerance (byte address 0) and iteration limit (byte address 4)
// over the APB port only while no search is in flight.
module bisection_root_search #(
	parameter int VALUE_WIDTH = 32,
	parameter int ITER_WIDTH  = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bsr_pkg::APB_ADDR_WIDTH-1:0]  paddr,
	input  logic [bsr_pkg::APB_DATA_WIDTH-1:0]  pwdata,
	output logic [bsr_pkg::APB_DATA_WIDTH-1:0]  prdata,
	output logic                                pready,
	bsr_in_if.sink                              item,
	bsr_out_if.source                           result
);
	import bsr_pkg::*;

	cfg_t cfg;

	// Input stage
	logic                   valid_s1;
	logic                   op_s1;
	logic [VALUE_WIDTH-1:0] bracket_low_s1;
	logic [VALUE_WIDTH-1:0] bracket_high_s1;
	logic [VALUE_WIDTH-1:0] func_value_s1;
	logic                   value_invalid_s1;

	// Decision outputs
	logic                   has_result;
	logic                   kind_c;
	logic [VALUE_WIDTH-1:0] query_point_c;
	logic [1:0]             status_c;
	logic [VALUE_WIDTH-1:0] root_c;
	logic [ITER_WIDTH-1:0]  iterations_c;

	// Output register
	logic                   out_valid_q;
	logic                   kind_q;
	logic [VALUE_WIDTH-1:0] query_point_q;
	logic [1:0]             status_q;
	logic [VALUE_WIDTH-1:0] root_q;
	logic [ITER_WIDTH-1:0]  iterations_q;

	logic advance;
	logic in_take;

	bsr_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the input stage when its beat makes no result or the output
	// register is free or being drained this cycle.
	assign advance = valid_s1 && (!has_result || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign in_take    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage; no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1            <= item.op;
			bracket_low_s1   <= item.bracket_low;
			bracket_high_s1  <= item.bracket_high;
			func_value_s1    <= item.func_value;
			value_invalid_s1 <= item.value_invalid;
		end
	end

	bsr_core #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.ITER_WIDTH  (ITER_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.advance         (advance),
		.op              (op_s1),
		.bracket_low     (bracket_low_s1),
		.bracket_high    (bracket_high_s1),
		.func_value      (func_value_s1),
		.value_invalid   (value_invalid_s1),
		.has_result      (has_result),
		.kind            (kind_c),
		.query_point     (query_point_c),
		.status          (status_c),
		.root            (root_c),
		.iterations_used (iterations_c)
	);

	// Hold the result until the sink takes it; load a new one as it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			kind_q        <= kind_c;
			query_point_q <= query_point_c;
			status_q      <= status_c;
			root_q        <= root_c;
			iterations_q  <= iterations_c;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.kind            = kind_q;
	assign result.query_point     = query_point_q;
	assign result.status          = status_q;
	assign result.root            = root_q;
	assign result.iterations_used = iterations_q;

`ifndef SYNTHESIS
	// A request beat carries no status, root or count
	a_request_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.kind == KIND_REQUEST) |->
			(result.status == ST_SUCCESS) && (result.root == '0)
			&& (result.iterations_used == '0))
		else $error("request beat carries done fields");

	// A failed search reports no root
	a_failed_no_root: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.kind == KIND_DONE)
		&& ((result.status == ST_NO_SIGN) || (result.status == ST_INVALID)) |->
			(result.root == '0))
		else $error("failed search reports a root");

	// A stalled input stage keeps its beat
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=>
			valid_s1 && $stable(op_s1) && $stable(func_value_s1)
			&& $stable(value_invalid_s1))
		else $error("input stage lost a stalled beat");
`endif

endmodule

>>> src/bsr_apb.sv
// APB-style configuration registers: tolerance and iteration limit.
// Depends on bsr_pkg for the register map and cfg_t.
module bsr_apb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bsr_pkg::APB_ADDR_WIDTH-1:0]  paddr,
	input  logic [bsr_pkg::APB_DATA_WIDTH-1:0]  pwdata,
	output logic [bsr_pkg::APB_DATA_WIDTH-1:0]  prdata,
	output logic                                pready,
	output bsr_pkg::cfg_t                       cfg
);
	import bsr_pkg::*;

	cfg_t     cfg_q;
	cfg_sel_t sel;
	logic     wr_en;

	assign pready = 1'b1;
	assign sel    = cfg_sel_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance       <= TOL_RESET;
			cfg_q.iteration_limit <= LIM_RESET;
		end else if (wr_en) begin
			unique case (sel)
				CFG_TOLERANCE:  cfg_q.tolerance       <= pwdata[TOL_WIDTH-1:0];
				CFG_ITER_LIMIT: cfg_q.iteration_limit <= pwdata[LIM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			CFG_TOLERANCE:  prdata = APB_DATA_WIDTH'(cfg_q.tolerance);
			CFG_ITER_LIMIT: prdata = APB_DATA_WIDTH'(cfg_q.iteration_limit);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> src/bsr_core.sv
// Search state and single-pass decision logic of the bisection root search.
// Depends on bsr_pkg for phase, status, kind and configuration types.
module bsr_core #(
	parameter int VALUE_WIDTH = 32,
	parameter int ITER_WIDTH  = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bsr_pkg::cfg_t          cfg,
	input  logic                   advance,
	input  logic                   op,
	input  logic [VALUE_WIDTH-1:0] bracket_low,
	input  logic [VALUE_WIDTH-1:0] bracket_high,
	input  logic [VALUE_WIDTH-1:0] func_value,
	input  logic                   value_invalid,
	output logic                   has_result,
	output logic                   kind,
	output logic [VALUE_WIDTH-1:0] query_point,
	output logic [1:0]             status,
	output logic [VALUE_WIDTH-1:0] root,
	output logic [ITER_WIDTH-1:0]  iterations_used
);
	import bsr_pkg::*;

	localparam int MW = ((VALUE_WIDTH > TOL_WIDTH) ? VALUE_WIDTH : TOL_WIDTH) + 1;
	localparam int CW = (ITER_WIDTH > LIM_WIDTH) ? ITER_WIDTH : LIM_WIDTH;

	phase_t                 phase_q, phase_d;
	logic [VALUE_WIDTH-1:0] low_end_q, low_end_d;
	logic [VALUE_WIDTH-1:0] high_end_q, high_end_d;
	logic [VALUE_WIDTH-1:0] low_value_q, low_value_d;
	logic [VALUE_WIDTH-1:0] mid_q, mid_d;
	logic [ITER_WIDTH-1:0]  count_q, count_d;

	logic                   is_start;
	logic [VALUE_WIDTH-1:0] mag_fv, mag_lv;
	logic                   fv_small, lv_small;
	logic                   fv_pos, fv_neg, lv_pos, lv_neg, opposite;
	logic [ITER_WIDTH-1:0]  count_inc;
	logic [LIM_WIDTH-1:0]   lim_eff;
	logic                   limit_hit;
	logic [VALUE_WIDTH:0]   width_diff;
	logic                   width_small, converged;
	logic [VALUE_WIDTH-1:0] next_low, next_high, mid_new;
	logic [VALUE_WIDTH:0]   mid_sum;
	status_t                status_c;
	kind_t                  kind_c;

	assign is_start = (op_t'(op) == OP_START);

	// Magnitudes fit VALUE_WIDTH bits unsigned, the most negative value included
	assign mag_fv   = func_value[VALUE_WIDTH-1] ? (~func_value + 1'b1) : func_value;
	assign mag_lv   = low_value_q[VALUE_WIDTH-1] ? (~low_value_q + 1'b1) : low_value_q;
	assign fv_small = MW'(mag_fv) < MW'(cfg.tolerance);
	assign lv_small = MW'(mag_lv) < MW'(cfg.tolerance);

	assign fv_neg   = func_value[VALUE_WIDTH-1];
	assign fv_pos   = !fv_neg && (func_value != '0);
	assign lv_neg   = low_value_q[VALUE_WIDTH-1];
	assign lv_pos   = !lv_neg && (low_value_q != '0);
	assign opposite = (lv_pos && fv_neg) || (lv_neg && fv_pos);

	// Saturate the midpoint count at the top of its range
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign lim_eff   = (cfg.iteration_limit == '0) ? LIM_WIDTH'(1) : cfg.iteration_limit;
	assign limit_hit = (CW'(count_inc) >= CW'(lim_eff)) || (count_inc == '1);

	// A reversed bracket counts as narrow enough
	assign width_diff  = {high_end_q[VALUE_WIDTH-1], high_end_q}
	                   - {low_end_q[VALUE_WIDTH-1], low_end_q};
	assign width_small = ($signed(low_end_q) > $signed(high_end_q))
	                   || (MW'(width_diff[VALUE_WIDTH:1]) < MW'(cfg.tolerance));
	assign converged   = fv_small || width_small;

	// Bracket after this value; only the midpoint phase moves an end
	always_comb begin
		next_low  = low_end_q;
		next_high = high_end_q;
		if (phase_q == PH_MID) begin
			if (opposite) next_high = mid_q;
			else          next_low  = mid_q;
		end
	end

	assign mid_sum = {next_low[VALUE_WIDTH-1], next_low} + {next_high[VALUE_WIDTH-1], next_high};
	assign mid_new = mid_sum[VALUE_WIDTH:1];

	// Next state
	always_comb begin
		phase_d     = phase_q;
		low_end_d   = low_end_q;
		high_end_d  = high_end_q;
		low_value_d = low_value_q;
		mid_d       = mid_q;
		count_d     = count_q;
		if (is_start) begin
			phase_d     = PH_LOW;
			low_end_d   = bracket_low;
			high_end_d  = bracket_high;
			low_value_d = '0;
			mid_d       = '0;
			count_d     = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_LOW: begin
					if (value_invalid) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d     = PH_HIGH;
						low_value_d = func_value;
					end
				end
				PH_HIGH: begin
					if (value_invalid || !opposite) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_MID;
						mid_d   = mid_new;
					end
				end
				PH_MID: begin
					count_d = count_inc;
					if (value_invalid || converged || limit_hit) begin
						phase_d = PH_IDLE;
					end else begin
						low_end_d  = next_low;
						high_end_d = next_high;
						mid_d      = mid_new;
						if (!opposite) low_value_d = func_value;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Result beat
	always_comb begin
		has_result      = 1'b0;
		kind_c          = KIND_REQUEST;
		query_point     = '0;
		status_c        = ST_SUCCESS;
		root            = '0;
		iterations_used = '0;
		if (is_start) begin
			has_result  = 1'b1;
			query_point = bracket_low;
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_LOW: begin
					has_result = 1'b1;
					if (value_invalid) begin
						kind_c   = KIND_DONE;
						status_c = ST_INVALID;
					end else begin
						query_point = high_end_q;
					end
				end
				PH_HIGH: begin
					has_result = 1'b1;
					if (value_invalid) begin
						kind_c   = KIND_DONE;
						status_c = ST_INVALID;
					end else if (!opposite) begin
						kind_c = KIND_DONE;
						if (lv_small)      root = low_end_q;
						else if (fv_small) root = high_end_q;
						else               status_c = ST_NO_SIGN;
					end else begin
						query_point = mid_new;
					end
				end
				PH_MID: begin
					has_result = 1'b1;
					if (value_invalid) begin
						kind_c          = KIND_DONE;
						status_c        = ST_INVALID;
						iterations_used = count_inc;
					end else if (converged || limit_hit) begin
						kind_c          = KIND_DONE;
						status_c        = converged ? ST_SUCCESS : ST_LIMIT;
						root            = mid_q;
						iterations_used = count_inc;
					end else begin
						query_point = mid_new;
					end
				end
				default: ;
			endcase
		end
	end

	assign kind   = kind_c;
	assign status = status_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			low_end_q   <= '0;
			high_end_q  <= '0;
			low_value_q <= '0;
			mid_q       <= '0;
			count_q     <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			low_end_q   <= low_end_d;
			high_end_q  <= high_end_d;
			low_value_q <= low_value_d;
			mid_q       <= mid_d;
			count_q     <= count_d;
		end
	end

endmodule
